// ===== rtl/core/rssd_pkg.sv =====
package rssd_pkg;

  localparam int MaxIds     = 8;
  localparam int QueueDepth = 10;

  localparam int SlotW  = $clog2(MaxIds);
  localparam int PosW   = $clog2(QueueDepth);
  localparam int CntW   = $clog2(QueueDepth + 1);
  localparam int AddrW  = $clog2(MaxIds * QueueDepth);
  // sum of samples: |S| <= 128*QueueDepth
  localparam int SumW   = 8 + $clog2(QueueDepth) + 1;
  // sum of squares: Q <= 16384*QueueDepth
  localparam int SqW    = 15 + $clog2(QueueDepth) + 1;
  // window and distance terms
  localparam int WideW  = 2 * SumW + 2;

  localparam logic [1:0] ActRegister = 2'd0;
  localparam logic [1:0] ActAppend   = 2'd1;
  localparam logic [1:0] ActDrop     = 2'd2;
  localparam logic [1:0] ActEval     = 2'd3;

  localparam logic [2:0] StOk         = 3'd0;
  localparam logic [2:0] StUnknown    = 3'd1;
  localparam logic [2:0] StDuplicate  = 3'd2;
  localparam logic [2:0] StTableFull  = 3'd3;
  localparam logic [2:0] StQueueFull  = 3'd4;
  localparam logic [2:0] StQueueEmpty = 3'd5;

  // command handed from the front end to the back end
  typedef struct packed {
    logic [1:0]        action;
    logic [7:0]        node_id;
    logic [7:0]        rssi_sample;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [2:0] status;
    logic [3:0] fill_level;
    logic       pair_valid;
    logic [7:0] suspect_id;
    logic [7:0] partner_id;
    logic       last;
  } res_t;

endpackage

// ===== rtl/core/rssd_cmd_queue.sv =====
module rssd_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rssd_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output rssd_pkg::cmd_t pop_data_o,
  output logic          empty_o
);
  import rssd_pkg::*;

  // two-entry queue between front and back end
  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
`endif

endmodule

// ===== rtl/core/rssd_engine.sv =====
module rssd_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  rssd_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           res_valid_o,
  output rssd_pkg::res_t res_o,
  input  logic           res_ready_i
);
  import rssd_pkg::*;

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SLookup = 4'd1;
  localparam logic [3:0] SExec   = 4'd2;
  localparam logic [3:0] SAccRd  = 4'd3;
  localparam logic [3:0] SAccMul = 4'd4;
  localparam logic [3:0] SAccAdd = 4'd5;
  localparam logic [3:0] SWidth  = 4'd6;
  localparam logic [3:0] SPair   = 4'd7;
  localparam logic [3:0] SEmit   = 4'd8;
  localparam logic [3:0] SDone   = 4'd9;
  localparam logic [3:0] SWait   = 4'd10;

  // per-slot control state
  logic [MaxIds-1:0] valid_q;
  logic [7:0]        id_q    [MaxIds];
  logic [PosW-1:0]   head_q  [MaxIds];
  logic [CntW-1:0]   count_q [MaxIds];
  // per-slot statistics from evaluation
  logic signed [SumW-1:0]  sum_q   [MaxIds];
  logic signed [WideW-1:0] width_q [MaxIds];

  // sample memory
  logic [7:0]       smem_q [MaxIds*QueueDepth];
  logic [7:0]       rd_q;

  logic [3:0]       state_q;
  cmd_t             cmd_q;
  logic             hit_q;
  logic [SlotW-1:0] slot_q;
  logic             free_ok_q;
  logic [SlotW-1:0] free_q;

  logic [SlotW-1:0] i_q, j_q;
  logic [CntW-1:0]  k_q;
  logic signed [SumW-1:0] acc_s_q;
  logic [SqW-1:0]         acc_q_q;
  logic signed [15:0]     sqr_q;
  logic signed [7:0]      xs_q;
  logic             any_q;
  logic             have_q;
  res_t             held_q;
  res_t             res_q;
  logic             res_vld_q;

  // slot lookup and free search, narrow and over MaxIds entries
  logic             hit_c;
  logic [SlotW-1:0] slot_c;
  logic             free_ok_c;
  logic [SlotW-1:0] free_c;
  always_comb begin
    hit_c = 1'b0;
    slot_c = '0;
    free_ok_c = 1'b0;
    free_c = '0;
    for (int s = MaxIds - 1; s >= 0; s--) begin
      if (valid_q[s] && id_q[s] == cmd_q.node_id) begin
        hit_c = 1'b1;
        slot_c = SlotW'(s);
      end
      if (!valid_q[s]) begin
        free_ok_c = 1'b1;
        free_c = SlotW'(s);
      end
    end
  end

  // memory address: slot*QueueDepth + position
  logic [PosW:0]     pos_c;
  logic [PosW-1:0]   pos_w;
  logic [AddrW-1:0]  addr_c;
  always_comb begin
    if (state_q == SAccRd) begin
      pos_c = {1'b0, head_q[i_q]} + (PosW+1)'(k_q);
    end else begin
      pos_c = {1'b0, head_q[slot_q]} + (PosW+1)'(count_q[slot_q]);
    end
    pos_w = (pos_c >= (PosW+1)'(QueueDepth)) ? PosW'(pos_c - (PosW+1)'(QueueDepth))
                                             : PosW'(pos_c);
    addr_c = AddrW'((state_q == SAccRd ? i_q : slot_q) * QueueDepth) + AddrW'(pos_w);
  end

  logic full_i_c, full_j_c;
  assign full_i_c = valid_q[i_q] && count_q[i_q] == CntW'(QueueDepth);
  assign full_j_c = valid_q[j_q] && count_q[j_q] == CntW'(QueueDepth);

  // pair test
  logic signed [WideW-1:0] diff_c, dist_c;
  logic                    pair_hit_c;
  always_comb begin
    diff_c = WideW'(sum_q[j_q]) - WideW'(sum_q[i_q]);
    dist_c = (diff_c < 0) ? -diff_c : diff_c;
    dist_c = WideW'(dist_c * QueueDepth);
    pair_hit_c = (j_q != i_q) && full_i_c && full_j_c && (dist_c <= width_q[i_q]);
  end

  logic out_free;
  logic res_load_c;
  assign out_free  = !res_vld_q || res_ready_i;
  assign res_load_c = out_free && (state_q == SEmit || state_q == SWait);
  assign cmd_pop_o = (state_q == SIdle) && cmd_valid_i;
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  function automatic res_t single(input logic [2:0] st, input logic [CntW-1:0] f);
    res_t r;
    r = '0;
    r.status = st;
    r.fill_level = 4'(f);
    r.last = 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (state_q == SExec && cmd_q.action == ActAppend && hit_q &&
        count_q[slot_q] < CntW'(QueueDepth)) begin
      smem_q[addr_c] <= cmd_q.rssi_sample;
    end
    rd_q <= smem_q[addr_c];
  end

  // output register: loaded from the held item, cleared on acceptance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_load_c) begin
      res_vld_q <= 1'b1;
    end else if (res_ready_i) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load_c) res_q <= held_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      valid_q   <= '0;
      slot_q    <= '0;
      for (int s = 0; s < MaxIds; s++) begin
        head_q[s]  <= '0;
        count_q[s] <= '0;
      end
    end else begin
      case (state_q)
        SIdle: begin
          if (cmd_valid_i) begin
            cmd_q   <= cmd_i;
            state_q <= SLookup;
          end
        end
        SLookup: begin
          hit_q     <= hit_c;
          slot_q    <= slot_c;
          free_ok_q <= free_ok_c;
          free_q    <= free_c;
          if (cmd_q.action == ActEval) begin
            i_q     <= '0;
            k_q     <= '0;
            acc_s_q <= '0;
            acc_q_q <= '0;
            state_q <= SAccRd;
          end else begin
            state_q <= SExec;
          end
        end
        SExec: begin
          case (cmd_q.action)
            ActRegister: begin
              if (hit_q) begin
                held_q <= single(StDuplicate, count_q[slot_q]);
              end else if (!free_ok_q) begin
                held_q <= single(StTableFull, '0);
              end else begin
                valid_q[free_q] <= 1'b1;
                id_q[free_q]    <= cmd_q.node_id;
                head_q[free_q]  <= '0;
                count_q[free_q] <= '0;
                held_q <= single(StOk, '0);
              end
            end
            ActAppend: begin
              if (!hit_q) begin
                held_q <= single(StUnknown, '0);
              end else if (count_q[slot_q] >= CntW'(QueueDepth)) begin
                held_q <= single(StQueueFull, count_q[slot_q]);
              end else begin
                count_q[slot_q] <= count_q[slot_q] + 1'b1;
                held_q <= single(StOk, count_q[slot_q] + 1'b1);
              end
            end
            default: begin
              if (!hit_q) begin
                held_q <= single(StUnknown, '0);
              end else if (count_q[slot_q] == '0) begin
                held_q <= single(StQueueEmpty, '0);
              end else begin
                head_q[slot_q] <= (head_q[slot_q] == PosW'(QueueDepth - 1)) ? '0
                                  : head_q[slot_q] + 1'b1;
                count_q[slot_q] <= count_q[slot_q] - 1'b1;
                held_q <= single(StOk, count_q[slot_q] - 1'b1);
              end
            end
          endcase
          state_q <= SWait;
        end
        // accumulate sum and sum of squares, one sample per pass through SAccRd, SAccMul and SAccAdd
        SAccRd: begin
          if (!full_i_c || k_q == CntW'(QueueDepth)) begin
            state_q <= SWidth;
          end else begin
            state_q <= SAccMul;
          end
        end
        SAccMul: begin
          xs_q    <= rd_q;
          sqr_q   <= $signed(rd_q) * $signed(rd_q);
          state_q <= SAccAdd;
        end
        SAccAdd: begin
          acc_s_q <= acc_s_q + SumW'(xs_q);
          acc_q_q <= acc_q_q + SqW'($unsigned(sqr_q));
          k_q     <= k_q + 1'b1;
          state_q <= SAccRd;
        end
        SWidth: begin
          sum_q[i_q]   <= acc_s_q;
          width_q[i_q] <= WideW'(acc_q_q) * WideW'(QueueDepth)
                          - WideW'(acc_s_q) * WideW'(acc_s_q);
          acc_s_q <= '0;
          acc_q_q <= '0;
          k_q     <= '0;
          if (i_q == SlotW'(MaxIds - 1)) begin
            i_q     <= '0;
            j_q     <= '0;
            any_q   <= 1'b0;
            have_q  <= 1'b0;
            state_q <= SPair;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= SAccRd;
          end
        end
        // pair scan; a found pair is held back until the next one is found, to mark the last one
        SPair: begin
          if (pair_hit_c && have_q) begin
            state_q <= SEmit;
          end else begin
            if (pair_hit_c) begin
              held_q <= '{status: StOk, fill_level: 4'd0, pair_valid: 1'b1,
                          suspect_id: id_q[i_q], partner_id: id_q[j_q], last: 1'b0};
              have_q <= 1'b1;
              any_q  <= 1'b1;
            end
            if (j_q == SlotW'(MaxIds - 1)) begin
              j_q <= '0;
              if (i_q == SlotW'(MaxIds - 1)) begin
                state_q <= SDone;
              end else begin
                i_q <= i_q + 1'b1;
              end
            end else begin
              j_q <= j_q + 1'b1;
            end
          end
        end
        // send the held pair, hold the current one in its place
        SEmit: begin
          if (out_free) begin
            held_q <= '{status: StOk, fill_level: 4'd0, pair_valid: 1'b1,
                        suspect_id: id_q[i_q], partner_id: id_q[j_q], last: 1'b0};
            if (j_q == SlotW'(MaxIds - 1)) begin
              j_q <= '0;
              if (i_q == SlotW'(MaxIds - 1)) begin
                state_q <= SDone;
              end else begin
                i_q <= i_q + 1'b1;
                state_q <= SPair;
              end
            end else begin
              j_q <= j_q + 1'b1;
              state_q <= SPair;
            end
          end
        end
        SDone: begin
          if (!any_q) begin
            held_q <= single(StOk, '0);
          end else begin
            held_q.last <= 1'b1;
          end
          state_q <= SWait;
        end
        SWait: begin
          if (out_free) begin
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

`ifndef SYNTH
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> state_q == SLookup) else $error("pop outside idle");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q[slot_q] <= CntW'(QueueDepth)) else $error("fifo count overflow");
  a_emit_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEmit && out_free) |=> res_vld_q && res_q.pair_valid && !res_q.last)
    else $error("pair emit mismatch");
`endif

endmodule

// ===== rtl/core/rssi_similarity_sybil_detector_unit.sv =====
// Actions 0..2: a command passes from the queue through SIdle, SLookup, SExec and SWait;
// its result is loaded into the output register once that register is free.
// Evaluate: a per-slot pass sums samples and squares of each full fifo, then one pair
// tested per cycle; each pair reported after the first also waits in SEmit on the output.
// Throughput: one item at a time in the back end; a 2-entry queue takes items meanwhile.
// Reset: asynchronous, active low; clears the id table, fifo pointers and handshakes.
module rssi_similarity_sybil_detector_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [7:0] node_id_i,
  input  logic signed [7:0] rssi_sample_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  output logic [3:0] fill_level_o,
  output logic       pair_valid_o,
  output logic [7:0] suspect_id_o,
  output logic [7:0] partner_id_o,
  output logic       last_o
);
  import rssd_pkg::*;

  cmd_t push_cmd, pop_cmd;
  logic q_full, q_empty, pop;
  res_t res;

  // front end: accept into the queue
  assign push_cmd   = '{action: action_i, node_id: node_id_i, rssi_sample: rssi_sample_i};
  assign in_ready_o = !q_full;

  rssd_cmd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i && !q_full),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .empty_o     (q_empty)
  );

  rssd_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (pop_cmd),
    .cmd_pop_o   (pop),
    .res_valid_o (out_valid_o),
    .res_o       (res),
    .res_ready_i (out_ready_i)
  );

  assign status_o     = res.status;
  assign fill_level_o = res.fill_level;
  assign pair_valid_o = res.pair_valid;
  assign suspect_id_o = res.suspect_id;
  assign partner_id_o = res.partner_id;
  assign last_o       = res.last;

endmodule
